### src/quadratic_root_solver_macros.svh
// Assertion macros used by the top-level solver module.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("solver assertion failed");

// The consequent must hold when the antecedent held, as sampled by $past at the given depth.
`define QRS_ASSERT_PAST(lbl, depth, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        $past(ante, depth) |-> (cons)) \
        else $error("solver assertion failed");

`endif

### src/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;

    localparam int DISC_W = 34;
    localparam int ROOT_W = 33;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_TWO    = 2'd1;
    localparam logic [1:0] ST_DOUBLE = 2'd2;
    localparam logic [1:0] ST_AZERO  = 2'd3;

    typedef logic signed [63:0] wide_t;

    function automatic logic signed [DISC_W-1:0] sat_disc(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (DISC_W - 1)) - wide_t'(1);
        lo = -hi - wide_t'(1);
        if (v > hi)
        begin
            return hi[DISC_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[DISC_W-1:0];
        end
        return v[DISC_W-1:0];
    endfunction

    function automatic logic signed [ROOT_W-1:0] sat_root(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (ROOT_W - 1)) - wide_t'(1);
        lo = -hi - wide_t'(1);
        if (v > hi)
        begin
            return hi[ROOT_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[ROOT_W-1:0];
        end
        return v[ROOT_W-1:0];
    endfunction

endpackage

### src/qrs_front.sv
`timescale 1ns / 1ps
module qrs_front
    import qrs_pkg::*;
#(
    parameter int CW = 16,
    parameter int DW = 34
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] a,
    input  logic signed [CW-1:0] b,
    input  logic signed [CW-1:0] c,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_a,
    output logic signed [CW-1:0] out_b,
    output logic signed [DW-1:0] out_disc,
    output logic [1:0]           out_status
);

    logic                   v1_reg;
    logic signed [CW-1:0]   a1_reg;
    logic signed [CW-1:0]   b1_reg;
    logic signed [2*CW-1:0] bb_reg;
    logic signed [2*CW-1:0] ac_reg;
    logic                   v2_reg;
    logic signed [CW-1:0]   a2_reg;
    logic signed [CW-1:0]   b2_reg;
    logic signed [DW-1:0]   disc_reg;
    logic signed [DW-1:0]   disc_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;

    always_comb
    begin
        disc_next = DW'(bb_reg) - (DW'(ac_reg) <<< 2);
        if (a1_reg == '0)
        begin
            status_next = ST_AZERO;
        end
        else if (disc_next < 0)
        begin
            status_next = ST_NONE;
        end
        else if (disc_next == '0)
        begin
            status_next = ST_DOUBLE;
        end
        else
        begin
            status_next = ST_TWO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg     <= a;
        b1_reg     <= b;
        bb_reg     <= b * b;
        ac_reg     <= a * c;
        a2_reg     <= a1_reg;
        b2_reg     <= b1_reg;
        disc_reg   <= disc_next;
        status_reg <= status_next;
    end

    assign out_valid  = v2_reg;
    assign out_a      = a2_reg;
    assign out_b      = b2_reg;
    assign out_disc   = disc_reg;
    assign out_status = status_reg;

endmodule

### src/qrs_sqrt.sv
`timescale 1ns / 1ps
module qrs_sqrt
#(
    parameter int RW = 33,
    parameter int SW = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2*RW-1:0] in_x,
    input  logic [SW-1:0]   in_side,
    output logic            out_valid,
    output logic [RW-1:0]   out_root,
    output logic            out_exact,
    output logic [SW-1:0]   out_side
);

    logic            v_reg    [1:RW];
    logic [2*RW-1:0] x_reg    [1:RW];
    logic [RW-1:0]   root_reg [1:RW];
    logic [RW+1:0]   rem_reg  [1:RW];
    logic [SW-1:0]   side_reg [1:RW];

    for (genvar k = 1; k <= RW; k++)
    begin : g_stage
        logic            v_in;
        logic [2*RW-1:0] x_in;
        logic [RW-1:0]   root_in;
        logic [RW+1:0]   rem_in;
        logic [SW-1:0]   side_in;
        logic [RW+1:0]   rem_sh;
        logic [RW+1:0]   trial;
        logic            fits;

        if (k == 1)
        begin : g_first
            assign v_in    = in_valid;
            assign x_in    = in_x;
            assign root_in = '0;
            assign rem_in  = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-1:0], x_in[2*RW-1:2*RW-2]};
        assign trial  = {root_in, 2'b01};
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[k]    <= x_in << 2;
            root_reg[k] <= {root_in[RW-2:0], fits};
            rem_reg[k]  <= fits ? (rem_sh - trial) : rem_sh;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = v_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_exact = (rem_reg[RW] == '0);
    assign out_side  = side_reg[RW];

endmodule

### src/qrs_div.sv
`timescale 1ns / 1ps
module qrs_div
#(
    parameter int NW  = 35,
    parameter int DVW = 17,
    parameter int SW  = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [NW-1:0]  in_num [0:1],
    input  logic [DVW-1:0] in_den,
    input  logic [SW-1:0]  in_side,
    output logic           out_valid,
    output logic [NW-1:0]  out_quo [0:1],
    output logic [SW-1:0]  out_side
);

    logic           v_reg    [1:NW];
    logic [NW-1:0]  n_reg    [1:NW][0:1];
    logic [DVW-1:0] rem_reg  [1:NW][0:1];
    logic [DVW-1:0] den_reg  [1:NW];
    logic [SW-1:0]  side_reg [1:NW];

    for (genvar k = 1; k <= NW; k++)
    begin : g_stage
        logic           v_in;
        logic [DVW-1:0] den_in;
        logic [SW-1:0]  side_in;

        if (k == 1)
        begin : g_first
            assign v_in    = in_valid;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = v_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[k]  <= den_in;
            side_reg[k] <= side_in;
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [NW-1:0]  n_in;
            logic [DVW-1:0] rem_in;
            logic [DVW:0]   rem_sh;
            logic [DVW:0]   rem_sub;
            logic           fits;

            if (k == 1)
            begin : g_first
                assign n_in   = in_num[l];
                assign rem_in = '0;
            end
            else
            begin : g_next
                assign n_in   = n_reg[k-1][l];
                assign rem_in = rem_reg[k-1][l];
            end

            assign rem_sh  = {rem_in, n_in[NW-1]};
            assign rem_sub = rem_sh - {1'b0, den_in};
            assign fits    = (rem_sh >= {1'b0, den_in});

            always_ff @(posedge clk)
            begin
                n_reg[k][l]   <= {n_in[NW-2:0], fits};
                rem_reg[k][l] <= fits ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
            end
        end
    end

    assign out_valid  = v_reg[NW];
    assign out_quo[0] = n_reg[NW][0];
    assign out_quo[1] = n_reg[NW][1];
    assign out_side   = side_reg[NW];

endmodule

### src/quadratic_root_solver.sv
`timescale 1ns / 1ps
// Real-root solver for a*x^2 + b*x + c = 0 with signed integer coefficients.
// An equation is transferred in at a rising clock edge where start is high and
// busy is low. The block never raises busy, so one equation may be transferred
// in on every cycle. Each result appears on discriminant, root_plus,
// root_minus and root_status for exactly one cycle with result_valid high.
// Results come back in input order, through the front end, the bit-per-stage
// square root, a register stage, the bit-per-stage two-lane divider and
// an output register. Throughput is one equation per cycle.
// The roots are signed fixed point with FRAC_BITS fraction bits, truncated
// toward zero, and are zero when there is no real root or when a is zero.
// Reset clears every valid bit in the pipeline, so equations in flight are
// dropped and no result is shown until a new transfer works its way through.
// The receiver cannot stall; it must take each result in the cycle it appears.
`include "quadratic_root_solver_macros.svh"
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COEF_WIDTH-1:0] coef_quadratic,
    input  logic signed [COEF_WIDTH-1:0] coef_linear,
    input  logic signed [COEF_WIDTH-1:0] coef_constant,
    output logic                         result_valid,
    output logic signed [DISC_W-1:0]     discriminant,
    output logic signed [ROOT_W-1:0]     root_plus,
    output logic signed [ROOT_W-1:0]     root_minus,
    output logic [1:0]                   root_status
);

    localparam int CW  = COEF_WIDTH;
    localparam int DW  = 2 * CW + 2;
    localparam int RW  = CW + FRAC_BITS + 1;
    localparam int NW  = CW + FRAC_BITS + 3;
    localparam int DVW = CW + 1;
    localparam int SQ_SW  = CW + CW + DW + 2;
    localparam int DIV_SW = 2 + DW + 2;
    localparam int LAT = 2 + RW + 1 + NW + 1;

    logic                 take;
    logic                 fr_valid;
    logic signed [CW-1:0] fr_a;
    logic signed [CW-1:0] fr_b;
    logic signed [DW-1:0] fr_disc;
    logic [1:0]           fr_status;
    logic [DW-2:0]        fr_mag;
    logic [2*RW-1:0]      sq_x;
    logic [SQ_SW-1:0]     sq_side_in;

    logic                 sq_valid;
    logic [RW-1:0]        sq_root;
    logic                 sq_exact;
    logic [SQ_SW-1:0]     sq_side;
    logic signed [CW-1:0] sq_a;
    logic signed [CW-1:0] sq_b;
    logic signed [DW-1:0] sq_disc;
    logic [1:0]           sq_status;

    logic signed [NW-1:0] nb;
    logic signed [NW-1:0] s_ext;
    logic signed [NW-1:0] kp;
    logic signed [NW-1:0] km;
    logic signed [NW-1:0] mp;
    logic signed [NW-1:0] mm;
    logic signed [NW-1:0] a_ext;

    logic                 pv_reg;
    logic [NW-1:0]        pnum_reg [0:1];
    logic [DVW-1:0]       pden_reg;
    logic [DIV_SW-1:0]    pside_reg;
    logic [NW-1:0]        pnum_next [0:1];
    logic [DVW-1:0]       pden_next;
    logic [DIV_SW-1:0]    pside_next;

    logic                 dv_valid;
    logic [NW-1:0]        dv_quo [0:1];
    logic [DIV_SW-1:0]    dv_side;
    logic                 dv_neg_p;
    logic                 dv_neg_m;
    logic signed [DW-1:0] dv_disc;
    logic [1:0]           dv_status;
    logic signed [NW:0]   qp;
    logic signed [NW:0]   qm;
    logic                 has_roots;

    logic                         out_v_reg;
    logic signed [DISC_W-1:0]     disc_reg;
    logic signed [ROOT_W-1:0]     rp_reg;
    logic signed [ROOT_W-1:0]     rm_reg;
    logic [1:0]                   status_reg;

    assign busy = 1'b0;
    assign take = start && !busy && rst_n;

    qrs_front #(
        .CW (CW),
        .DW (DW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (take),
        .a          (coef_quadratic),
        .b          (coef_linear),
        .c          (coef_constant),
        .out_valid  (fr_valid),
        .out_a      (fr_a),
        .out_b      (fr_b),
        .out_disc   (fr_disc),
        .out_status (fr_status)
    );

    assign fr_mag     = fr_disc[DW-1] ? '0 : fr_disc[DW-2:0];
    assign sq_x       = (2*RW)'(fr_mag) << (2 * FRAC_BITS);
    assign sq_side_in = {fr_a, fr_b, fr_disc, fr_status};

    qrs_sqrt #(
        .RW (RW),
        .SW (SQ_SW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_x      (sq_x),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_exact (sq_exact),
        .out_side  (sq_side)
    );

    assign {sq_a, sq_b, sq_disc, sq_status} = sq_side;

    always_comb
    begin
        nb    = -(NW'(sq_b) <<< FRAC_BITS);
        s_ext = signed'(NW'(sq_root));
        a_ext = NW'(sq_a);
        kp    = nb + s_ext;
        km    = sq_exact ? (nb - s_ext) : (nb - s_ext - NW'(1));
        mp    = (!sq_exact && kp < 0) ? (kp + NW'(1)) : kp;
        mm    = (!sq_exact && km < 0) ? (km + NW'(1)) : km;
        pnum_next[0] = mp[NW-1] ? NW'(-mp) : NW'(mp);
        pnum_next[1] = mm[NW-1] ? NW'(-mm) : NW'(mm);
        if (sq_a == '0)
        begin
            pden_next = DVW'(1);
        end
        else
        begin
            pden_next = sq_a[CW-1] ? DVW'(-(a_ext <<< 1)) : DVW'(a_ext <<< 1);
        end
        pside_next = {mp[NW-1] ^ sq_a[CW-1], mm[NW-1] ^ sq_a[CW-1], sq_disc, sq_status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pnum_reg[0] <= pnum_next[0];
        pnum_reg[1] <= pnum_next[1];
        pden_reg    <= pden_next;
        pside_reg   <= pside_next;
    end

    qrs_div #(
        .NW  (NW),
        .DVW (DVW),
        .SW  (DIV_SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pv_reg),
        .in_num    (pnum_reg),
        .in_den    (pden_reg),
        .in_side   (pside_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    assign {dv_neg_p, dv_neg_m, dv_disc, dv_status} = dv_side;
    assign qp = dv_neg_p ? -signed'({1'b0, dv_quo[0]}) : signed'({1'b0, dv_quo[0]});
    assign qm = dv_neg_m ? -signed'({1'b0, dv_quo[1]}) : signed'({1'b0, dv_quo[1]});
    assign has_roots = (dv_status == ST_TWO) || (dv_status == ST_DOUBLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        disc_reg   <= sat_disc(wide_t'(dv_disc));
        rp_reg     <= has_roots ? sat_root(wide_t'(qp)) : '0;
        rm_reg     <= has_roots ? sat_root(wide_t'(qm)) : '0;
        status_reg <= dv_status;
    end

    assign result_valid = out_v_reg;
    assign discriminant = disc_reg;
    assign root_plus    = rp_reg;
    assign root_minus   = rm_reg;
    assign root_status  = status_reg;

    function automatic logic has_roots_out(input logic [1:0] st);
        return (st == ST_TWO) || (st == ST_DOUBLE);
    endfunction

    `QRS_ASSERT_PAST(a_latency, LAT, take, result_valid)
    `QRS_ASSERT_IMP(a_no_roots_zero, result_valid && !has_roots_out(root_status),
        root_plus == '0 && root_minus == '0)
    `QRS_ASSERT_IMP(a_double_equal, result_valid && root_status == ST_DOUBLE, root_plus == root_minus)
    `QRS_ASSERT_IMP(a_none_negative, result_valid && root_status == ST_NONE, discriminant < 0)

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import qrs_pkg::*;

    localparam int COEF_W = 16;
    localparam int FRAC = 16;
    localparam int LATENCY = 72;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 1150;

    typedef struct packed {
        logic signed [DISC_W-1:0] disc;
        logic signed [ROOT_W-1:0] rplus;
        logic signed [ROOT_W-1:0] rminus;
        logic [1:0]               status;
    } roots_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [COEF_W-1:0] coef_quadratic;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_constant;
    logic result_valid;
    logic signed [DISC_W-1:0] discriminant;
    logic signed [ROOT_W-1:0] root_plus;
    logic signed [ROOT_W-1:0] root_minus;
    logic [1:0] root_status;

    roots_t pending_roots[$];
    int errors = 0;
    int idle_cycles = 0;
    bit bursty = 0;

    quadratic_root_solver DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .coef_quadratic(coef_quadratic),
        .coef_linear(coef_linear),
        .coef_constant(coef_constant),
        .result_valid(result_valid),
        .discriminant(discriminant),
        .root_plus(root_plus),
        .root_minus(root_minus),
        .root_status(root_status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // Truncation toward zero of a quotient whose numerator lies strictly above
    // k when the square root was not exact.
    function automatic longint div_toward_zero(longint k, bit exact, longint den);
        longint m;
        m = k;
        if (!exact && k < 0)
        begin
            m = k + 1;
        end
        return m / den;
    endfunction

    function automatic roots_t solve_equation(longint a, longint b, longint c);
        roots_t r;
        longint d;
        longint rp;
        longint rm;
        longint s;
        longint nb;
        bit exact;
        bit [127:0] scaled;
        bit [127:0] root;
        bit [127:0] rem;
        bit [127:0] trial;
        d = b * b - 4 * a * c;
        rp = 0;
        rm = 0;
        if (a == 0)
        begin
            r.status = ST_AZERO;
        end
        else if (d < 0)
        begin
            r.status = ST_NONE;
        end
        else
        begin
            scaled = 128'(d) << (2 * FRAC);
            root = '0;
            rem = '0;
            for (int i = 63; i >= 0; i--)
            begin
                rem = (rem << 2) | ((scaled >> (2 * i)) & 128'd3);
                trial = (root << 2) | 128'd1;
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    root = (root << 1) | 128'd1;
                end
                else
                begin
                    root = root << 1;
                end
            end
            exact = (rem == 0);
            s = longint'(root[63:0]);
            nb = -b * (longint'(1) <<< FRAC);
            r.status = (d == 0) ? ST_DOUBLE : ST_TWO;
            rp = div_toward_zero(nb + s, exact, 2 * a);
            rm = exact ? div_toward_zero(nb - s, 1'b1, 2 * a)
                       : div_toward_zero(nb - s - 1, 1'b0, 2 * a);
        end
        r.disc = DISC_W'(clamp(d, DISC_W));
        r.rplus = ROOT_W'(clamp(rp, ROOT_W));
        r.rminus = ROOT_W'(clamp(rm, ROOT_W));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Caller is at a rising edge; returns at a rising edge.
    task automatic send_equation(longint a, longint b, longint c);
        int gap;
        start <= 1'b1;
        coef_quadratic <= a[COEF_W-1:0];
        coef_linear <= b[COEF_W-1:0];
        coef_constant <= c[COEF_W-1:0];
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_roots.push_back(solve_equation(a, b, c));
        if (bursty)
        begin
            gap = 0;
        end
        else if ($urandom_range(0, 9) < 6)
        begin
            gap = 0;
        end
        else if ($urandom_range(0, 9) < 8)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_roots.size() == 0)
            begin
                report_mismatch("unexpected result", longint'(discriminant), 0);
            end
            else
            begin
                roots_t want;
                want = pending_roots.pop_front();
                if (discriminant !== want.disc)
                begin
                    report_mismatch("discriminant", longint'(discriminant),
                                    longint'(want.disc));
                end
                if (root_plus !== want.rplus)
                begin
                    report_mismatch("root_plus", longint'(root_plus), longint'(want.rplus));
                end
                if (root_minus !== want.rminus)
                begin
                    report_mismatch("root_minus", longint'(root_minus),
                                    longint'(want.rminus));
                end
                if (root_status !== want.status)
                begin
                    report_mismatch("root_status", longint'(root_status),
                                    longint'(want.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic longint rand_coef();
        return longint'($signed(16'($urandom)));
    endfunction

    task automatic test_extremes();
        send_equation(-32768, -32768, -32768);
        send_equation(-32768, -32768, 32767);
        send_equation(32767, -32768, -32768);
        send_equation(32767, 32767, 32767);
        send_equation(-32768, 32767, 32767);
        send_equation(1, -32768, -32768);
        send_equation(-1, 32767, 0);
        send_equation(1, 0, -32768);
    endtask

    task automatic test_special_cases();
        send_equation(0, 5, 3);
        send_equation(0, -32768, 32767);
        send_equation(0, 0, 0);
        send_equation(1, 0, 1);
        send_equation(-3, 1, -7);
        send_equation(1, 2, 1);
        send_equation(-32768, 0, 0);
        send_equation(4, -12, 9);
        send_equation(1, -3, 2);
        send_equation(-2, 3, 5);
        send_equation(3, 1, -1);
        send_equation(-7, -5, 11);
    endtask

    task automatic test_random();
        longint a;
        longint b;
        longint c;
        longint p;
        longint q;
        longint g;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                bursty = ($urandom_range(0, 3) == 0);
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    a = 0;
                    b = rand_coef();
                    c = rand_coef();
                end
                1:
                begin
                    g = longint'($urandom_range(1, 8)) * ($urandom_range(0, 1) ? 1 : -1);
                    p = $urandom_range(1, 20);
                    q = longint'($urandom_range(0, 40)) - 20;
                    a = g * p * p;
                    b = 2 * g * p * q;
                    c = g * q * q;
                end
                2, 3:
                begin
                    a = longint'($urandom_range(0, 32)) - 16;
                    b = longint'($urandom_range(0, 64)) - 32;
                    c = longint'($urandom_range(0, 64)) - 32;
                end
                default:
                begin
                    a = rand_coef();
                    b = rand_coef();
                    c = rand_coef();
                end
            endcase
            send_equation(a, b, c);
        end
        bursty = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        coef_quadratic = '0;
        coef_linear = '0;
        coef_constant = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_special_cases();
        test_random();
        start <= 1'b0;
        while (pending_roots.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### quadratic_root_solver.f
+incdir+src
src/qrs_pkg.sv
src/qrs_front.sv
src/qrs_sqrt.sv
src/qrs_div.sv
src/quadratic_root_solver.sv
tb/sv/tb_top.sv
